// ===== rtl/fbar_pkg.sv =====
// ----------------------------------------------------------------------------
// fbar_pkg
// Shared types, constants and helpers of the framebuffer area rotator.
// ----------------------------------------------------------------------------
package fbar_pkg;

  // field widths
  localparam int unsigned POS_W      = 10;  // area bounds, column / row
  localparam int unsigned DIM_W      = 11;  // frame width / height
  localparam int unsigned IDX_W      = 20;  // destination pixel index
  localparam int unsigned PIX_W      = 32;  // pixel value
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned BYTE_W     = 8;

  localparam logic [DIM_W-1:0] MAX_WIDTH  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] MAX_HEIGHT = DIM_W'(1024);

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rotation_e;

  typedef enum logic [2:0] {
    PM_8BPP      = 3'd0,
    PM_16BPP     = 3'd1,
    PM_16BPP_SWP = 3'd2,
    PM_24BPP     = 3'd3,
    PM_32BPP     = 3'd4
  } pixel_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATION     = 3'd0,
    REG_AREA_LEFT    = 3'd1,
    REG_AREA_TOP     = 3'd2,
    REG_AREA_RIGHT   = 3'd3,
    REG_AREA_BOTTOM  = 3'd4,
    REG_FRAME_WIDTH  = 3'd5,
    REG_FRAME_HEIGHT = 3'd6,
    REG_PIXEL_MODE   = 3'd7
  } reg_index_e;

  // clamped geometry seen by the datapath
  typedef struct packed {
    rotation_e        rotation;
    logic [2:0]       pixel_mode;
    logic [DIM_W-1:0] w;        // 1 .. MAX_WIDTH
    logic [DIM_W-1:0] h;        // 1 .. MAX_HEIGHT
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] top;
    logic [POS_W-1:0] col_max;  // columns in area minus one
    logic [POS_W-1:0] row_max;  // rows in area minus one
  } geom_t;

  function automatic logic [PIX_W-1:0] shape_pixel(input logic [2:0]       mode,
                                                   input logic [PIX_W-1:0] p);
    logic [PIX_W-1:0] r;
    case (pixel_mode_e'(mode))
      PM_8BPP:      r = {24'd0, p[7:0]};
      PM_16BPP:     r = {16'd0, p[15:0]};
      PM_16BPP_SWP: r = {16'd0, p[BYTE_W-1:0], p[2*BYTE_W-1:BYTE_W]};
      PM_24BPP:     r = {8'd0, p[23:0]};
      default:      r = p;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/fbar_if.sv =====
// ----------------------------------------------------------------------------
// fbar interfaces
// Valid/ready channels for source pixels, results and register writes.
// ----------------------------------------------------------------------------
interface fbar_pix_in_if import fbar_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface fbar_pix_out_if import fbar_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] dest_index;
  logic [PIX_W-1:0] pixel_out;
  logic             last_pixel;

  modport source (output valid, output dest_index, output pixel_out,
                  output last_pixel, input ready);
  modport sink   (input valid, input dest_index, input pixel_out,
                  input last_pixel, output ready);
endinterface

interface fbar_cfg_if import fbar_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== rtl/framebuffer_area_rotator.sv =====
// ----------------------------------------------------------------------------
// framebuffer_area_rotator
// Streams the pixels of a source area and gives rotated framebuffer indexes.
// ----------------------------------------------------------------------------
// pix_in_i carries source pixels of the configured area in raster order;
// each request on pix_out_o holds the destination pixel index for the chosen
// rotation, the pixel shaped to the pixel mode and a flag on the area's last
// pixel, after which the walk restarts at the area's first pixel.
// cfg_i writes the registers (index as listed: rotation, area bounds, frame
// size, pixel mode); it is always ready and must only be used while no pixel
// is in flight. register writes leave the position in the area unchanged.
// an accepted pixel passes the input register, then the result register,
// and is offered on pix_out_o from the result register.
// throughput: one pixel per cycle while the receiver keeps taking results;
// the single multiplier sits between the input register and the result
// register.
// when the receiver stalls, the result register holds its request and the
// input register fills; pix_in_i.ready drops only when both are full, and
// returns in the same cycle the receiver takes the result.
// reset clears the position, the valid flags and the registers to rotation
// 0, a one-pixel area at the origin, a 1024 x 1024 frame and 16bpp.
// ----------------------------------------------------------------------------
module framebuffer_area_rotator import fbar_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  fbar_cfg_if.sink        cfg_i,
  fbar_pix_in_if.sink     pix_in_i,
  fbar_pix_out_if.source  pix_out_o
);

  geom_t            geom;
  logic             in_acc;
  logic             s1_en, s2_en;

  // walk outputs for the pixel being accepted
  logic [POS_W-1:0] walk_x, walk_y;
  logic             walk_last;

  // input register
  logic             s1_valid_q;
  logic [POS_W-1:0] s1_x_q, s1_y_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic             s1_last_q;

  // result register
  logic             out_valid_q;
  logic [IDX_W-1:0] out_index_q;
  logic [PIX_W-1:0] out_pix_q;
  logic             out_last_q;
  logic [IDX_W-1:0] index;

  fbar_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .geom_o (geom)
  );

  // each stage moves when the one after it is free or drains
  assign s2_en          = !out_valid_q || pix_out_o.ready;
  assign s1_en          = !s1_valid_q || s2_en;
  assign pix_in_i.ready = s1_en;
  assign in_acc         = pix_in_i.valid && s1_en;

  fbar_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .geom_i (geom),
    .step_i (in_acc),
    .x_o    (walk_x),
    .y_o    (walk_y),
    .last_o (walk_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= pix_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q    <= walk_x;
      s1_y_q    <= walk_y;
      s1_pix_q  <= shape_pixel(geom.pixel_mode, pix_in_i.pixel_in);
      s1_last_q <= walk_last;
    end
  end

  fbar_index u_index (
    .geom_i  (geom),
    .x_i     (s1_x_q),
    .y_i     (s1_y_q),
    .index_o (index)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      out_index_q <= index;
      out_pix_q   <= s1_pix_q;
      out_last_q  <= s1_last_q;
    end
  end

  assign pix_out_o.valid      = out_valid_q;
  assign pix_out_o.dest_index = out_index_q;
  assign pix_out_o.pixel_out  = out_pix_q;
  assign pix_out_o.last_pixel = out_last_q;

endmodule

// ===== rtl/fbar_cfg.sv =====
// ----------------------------------------------------------------------------
// fbar_cfg
// Register file and clamped area geometry.
// ----------------------------------------------------------------------------
module fbar_cfg import fbar_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fbar_cfg_if.sink   cfg_i,
  output geom_t      geom_o
);

  rotation_e        rotation_q;
  logic [POS_W-1:0] area_left_q, area_top_q, area_right_q, area_bottom_q;
  logic [DIM_W-1:0] frame_width_q, frame_height_q;
  logic [2:0]       pixel_mode_q;

  logic             swapped;
  logic [DIM_W-1:0] w, h, xlim, ylim;
  logic [POS_W-1:0] left, right, top, bottom;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q     <= ROT_0;
      area_left_q    <= '0;
      area_top_q     <= '0;
      area_right_q   <= '0;
      area_bottom_q  <= '0;
      frame_width_q  <= MAX_WIDTH;
      frame_height_q <= MAX_HEIGHT;
      pixel_mode_q   <= PM_16BPP;
    end else if (cfg_i.valid) begin
      case (reg_index_e'(cfg_i.reg_index))
        REG_ROTATION:     rotation_q     <= rotation_e'(cfg_i.wr_data[1:0]);
        REG_AREA_LEFT:    area_left_q    <= cfg_i.wr_data[POS_W-1:0];
        REG_AREA_TOP:     area_top_q     <= cfg_i.wr_data[POS_W-1:0];
        REG_AREA_RIGHT:   area_right_q   <= cfg_i.wr_data[POS_W-1:0];
        REG_AREA_BOTTOM:  area_bottom_q  <= cfg_i.wr_data[POS_W-1:0];
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_i.wr_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_i.wr_data[DIM_W-1:0];
        REG_PIXEL_MODE:   pixel_mode_q   <= cfg_i.wr_data[2:0];
        default:          ;
      endcase
    end
  end

  // frame size limited to 1 .. max
  always_comb begin
    w = frame_width_q;
    if (frame_width_q == '0) w = DIM_W'(1);
    else if (frame_width_q > MAX_WIDTH) w = MAX_WIDTH;
    h = frame_height_q;
    if (frame_height_q == '0) h = DIM_W'(1);
    else if (frame_height_q > MAX_HEIGHT) h = MAX_HEIGHT;
  end

  // source extents swap for the quarter turns
  assign swapped = (rotation_q == ROT_90) || (rotation_q == ROT_270);
  assign xlim    = (swapped ? h : w) - DIM_W'(1);
  assign ylim    = (swapped ? w : h) - DIM_W'(1);

  assign left   = ({1'b0, area_left_q}   > xlim) ? xlim[POS_W-1:0] : area_left_q;
  assign right  = ({1'b0, area_right_q}  > xlim) ? xlim[POS_W-1:0] : area_right_q;
  assign top    = ({1'b0, area_top_q}    > ylim) ? ylim[POS_W-1:0] : area_top_q;
  assign bottom = ({1'b0, area_bottom_q} > ylim) ? ylim[POS_W-1:0] : area_bottom_q;

  always_comb begin
    geom_o.rotation   = rotation_q;
    geom_o.pixel_mode = pixel_mode_q;
    geom_o.w          = w;
    geom_o.h          = h;
    geom_o.left       = left;
    geom_o.top        = top;
    // reversed bounds give a single column / row
    geom_o.col_max    = (right >= left) ? right - left : '0;
    geom_o.row_max    = (bottom >= top) ? bottom - top : '0;
  end

endmodule

// ===== rtl/fbar_walk.sv =====
// ----------------------------------------------------------------------------
// fbar_walk
// Raster position counter inside the source area.
// ----------------------------------------------------------------------------
module fbar_walk import fbar_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  geom_t            geom_i,
  input  logic             step_i,
  output logic [POS_W-1:0] x_o,
  output logic [POS_W-1:0] y_o,
  output logic             last_o
);

  logic [POS_W-1:0] col_q, col_d, row_q, row_d;
  logic [POS_W-1:0] col_eff, row_eff;
  logic             last_col, last_row;

  // offsets past a shrunk area sit on its last column / row
  assign col_eff  = (col_q > geom_i.col_max) ? geom_i.col_max : col_q;
  assign row_eff  = (row_q > geom_i.row_max) ? geom_i.row_max : row_q;
  assign last_col = col_eff == geom_i.col_max;
  assign last_row = row_eff == geom_i.row_max;

  assign x_o    = geom_i.left + col_eff;
  assign y_o    = geom_i.top + row_eff;
  assign last_o = last_col && last_row;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_eff + POS_W'(1);
      end else begin
        col_d = col_eff + POS_W'(1);
        row_d = row_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== rtl/fbar_index.sv =====
// ----------------------------------------------------------------------------
// fbar_index
// Destination pixel index after rotation: one multiply and one add.
// ----------------------------------------------------------------------------
module fbar_index import fbar_pkg::*; (
  input  geom_t            geom_i,
  input  logic [POS_W-1:0] x_i,
  input  logic [POS_W-1:0] y_i,
  output logic [IDX_W-1:0] index_o
);

  logic [DIM_W-1:0]       w_m1, h_m1;
  logic [DIM_W-1:0]       h_m1_x, h_m1_y, w_m1_x, w_m1_y;
  logic [POS_W-1:0]       mul_a, add_b;
  logic [POS_W+DIM_W-1:0] prod;
  logic [POS_W+DIM_W:0]   sum;

  assign w_m1   = geom_i.w - DIM_W'(1);
  assign h_m1   = geom_i.h - DIM_W'(1);
  assign h_m1_x = h_m1 - DIM_W'(x_i);
  assign h_m1_y = h_m1 - DIM_W'(y_i);
  assign w_m1_x = w_m1 - DIM_W'(x_i);
  assign w_m1_y = w_m1 - DIM_W'(y_i);

  // index = row * W + column in destination space
  always_comb begin
    case (geom_i.rotation)
      ROT_0: begin
        mul_a = y_i;
        add_b = x_i;
      end
      ROT_90: begin
        mul_a = h_m1_x[POS_W-1:0];
        add_b = y_i;
      end
      ROT_180: begin
        mul_a = h_m1_y[POS_W-1:0];
        add_b = w_m1_x[POS_W-1:0];
      end
      default: begin
        mul_a = x_i;
        add_b = w_m1_y[POS_W-1:0];
      end
    endcase
  end

  assign prod    = (POS_W+DIM_W)'(mul_a) * (POS_W+DIM_W)'(geom_i.w);
  assign sum     = {1'b0, prod} + (POS_W+DIM_W+1)'(add_b);
  assign index_o = sum[IDX_W-1:0];

endmodule

// ===== tb/sv/framebuffer_area_rotator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framebuffer_area_rotator_tb
// Streams source pixels through the rotator under many area, frame and
// pixel mode settings, predicts each destination index, shaped pixel and
// last pixel flag, and compares every result with the prediction in order.
// ----------------------------------------------------------------------------
module framebuffer_area_rotator_tb;
  import fbar_pkg::*;

  localparam int unsigned RUN_LIMIT = 500000;  // cycles before giving up
  localparam int unsigned MAX_IDLE  = 12;
  localparam int unsigned RAND_PIXELS = 1000;

  typedef struct packed {
    logic [IDX_W-1:0] dest_index;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } placed_pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fbar_cfg_if     cfg_if ();
  fbar_pix_in_if  pix_in_if ();
  fbar_pix_out_if pix_out_if ();

  framebuffer_area_rotator u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_if),
    .pix_in_i  (pix_in_if),
    .pix_out_o (pix_out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the registers and of the walk position
  rotation_e        geo_rot;
  logic [POS_W-1:0] geo_left, geo_top, geo_right, geo_bottom;
  logic [DIM_W-1:0] geo_fw, geo_fh;
  logic [2:0]       geo_mode;
  logic [POS_W-1:0] walk_col, walk_row;

  logic [PIX_W-1:0] pixel_q[$];          // pixels waiting to be sent
  placed_pixel_t    placed_q[$];         // predicted results, oldest first
  int unsigned      mismatches = 0;
  int unsigned      cycle_cnt  = 0;

  // handshake bookkeeping shared between the posedge and negedge blocks
  bit          pix_taken = 1'b0;
  bit          res_taken = 1'b0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;             // long receiver hold-off

  // next result for one source pixel; advances the walk like the block does
  function automatic placed_pixel_t rotate_pixel(input logic [PIX_W-1:0] p);
    placed_pixel_t res;
    int unsigned   w, h, xlim, ylim, left, right, top, bottom;
    int unsigned   cols, rows, x, y, idx;
    bit            end_col, end_row;
    // out-of-range frame sizes fall back to 1 or the maximum
    w = (geo_fw == 0) ? 1 : ((geo_fw > MAX_WIDTH) ? MAX_WIDTH : geo_fw);
    h = (geo_fh == 0) ? 1 : ((geo_fh > MAX_HEIGHT) ? MAX_HEIGHT : geo_fh);
    // 90 / 270 swap the source limits
    if (geo_rot == ROT_90 || geo_rot == ROT_270) begin
      xlim = h - 1;
      ylim = w - 1;
    end else begin
      xlim = w - 1;
      ylim = h - 1;
    end
    left   = (geo_left < xlim) ? geo_left : xlim;
    right  = (geo_right < xlim) ? geo_right : xlim;
    top    = (geo_top < ylim) ? geo_top : ylim;
    bottom = (geo_bottom < ylim) ? geo_bottom : ylim;
    // reversed bounds collapse to a single column / row
    cols = (right >= left) ? right - left + 1 : 1;
    rows = (bottom >= top) ? bottom - top + 1 : 1;
    // area shrunk under the walk: pin to the last column / row
    if (walk_col > cols - 1) walk_col = POS_W'(cols - 1);
    if (walk_row > rows - 1) walk_row = POS_W'(rows - 1);
    x = left + walk_col;
    y = top + walk_row;
    case (geo_rot)
      ROT_0:   idx = y * w + x;
      ROT_90:  idx = (h - 1 - x) * w + y;
      ROT_180: idx = (h - 1 - y) * w + (w - 1 - x);
      default: idx = x * w + (w - 1 - y);
    endcase
    end_col = (walk_col == cols - 1);
    end_row = (walk_row == rows - 1);
    res.dest_index = IDX_W'(idx);
    case (geo_mode)
      PM_8BPP:      res.pixel = p & 32'h0000_00ff;
      PM_16BPP:     res.pixel = p & 32'h0000_ffff;
      PM_16BPP_SWP: res.pixel = {16'd0, p[7:0], p[15:8]};
      PM_24BPP:     res.pixel = p & 32'h00ff_ffff;
      default:      res.pixel = p;  // 32bpp and the unused codes
    endcase
    res.last = end_col && end_row;
    if (end_col) begin
      walk_col = '0;
      walk_row = end_row ? '0 : walk_row + 1'b1;
    end else begin
      walk_col = walk_col + 1'b1;
    end
    return res;
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk_i) begin : edge_monitor
    placed_pixel_t got, want;
    if (rst_ni) begin
      if (pix_in_if.valid && pix_in_if.ready) begin
        placed_q.push_back(rotate_pixel(pix_in_if.pixel_in));
        pix_taken = 1'b1;
      end
      if (pix_out_if.valid && pix_out_if.ready) begin
        res_taken = 1'b1;
        got = '{pix_out_if.dest_index, pix_out_if.pixel_out, pix_out_if.last_pixel};
        if (placed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: index %0d pixel %08h last %0b",
                     got.dest_index, got.pixel, got.last);
        end else begin
          want = placed_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected index %0d pixel %08h last %0b, got index %0d pixel %08h last %0b",
                       want.dest_index, want.pixel, want.last,
                       got.dest_index, got.pixel, got.last);
          end
        end
      end
    end
  end

  // long receiver hold-off, counted down on its own
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left--;
  end

  // pixel sender: random gap after each accepted request
  always @(negedge clk_i) begin : pixel_sender
    logic             nxt_valid;
    logic [PIX_W-1:0] nxt_pixel;
    nxt_valid = pix_in_if.valid;
    nxt_pixel = pix_in_if.pixel_in;
    if (pix_taken) begin
      pix_taken = 1'b0;
      nxt_valid = 1'b0;
    end
    if (rst_ni && !nxt_valid) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (pixel_q.size() != 0) begin
        nxt_pixel = pixel_q.pop_front();
        nxt_valid = 1'b1;
        tx_gap    = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
    end
    pix_in_if.valid    <= nxt_valid;
    pix_in_if.pixel_in <= nxt_pixel;
  end

  // result receiver: random stall after each taken result
  always @(negedge clk_i) begin
    if (res_taken) begin
      res_taken = 1'b0;
      rx_gap    = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    end
    if (rx_gap > 0) begin
      rx_gap--;
      pix_out_if.ready <= 1'b0;
    end else begin
      pix_out_if.ready <= rst_ni && (hold_left == 0);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one register write, mirrored into the predictor on acceptance
  task automatic write_reg(input reg_index_e idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= d;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_ROTATION:     geo_rot    = rotation_e'(d[1:0]);
      REG_AREA_LEFT:    geo_left   = d[POS_W-1:0];
      REG_AREA_TOP:     geo_top    = d[POS_W-1:0];
      REG_AREA_RIGHT:   geo_right  = d[POS_W-1:0];
      REG_AREA_BOTTOM:  geo_bottom = d[POS_W-1:0];
      REG_FRAME_WIDTH:  geo_fw     = d[DIM_W-1:0];
      REG_FRAME_HEIGHT: geo_fh     = d[DIM_W-1:0];
      default:          geo_mode   = d[2:0];
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // full register set; junk above the field width must be ignored
  task automatic set_geom(input rotation_e rot, input int unsigned l, input int unsigned t,
                          input int unsigned r, input int unsigned b, input int unsigned fw,
                          input int unsigned fh, input logic [2:0] mode);
    write_reg(REG_ROTATION,     ($urandom() << DIM_W) | rot);
    write_reg(REG_AREA_LEFT,    ($urandom() << DIM_W) | l);
    write_reg(REG_AREA_TOP,     ($urandom() << DIM_W) | t);
    write_reg(REG_AREA_RIGHT,   ($urandom() << DIM_W) | r);
    write_reg(REG_AREA_BOTTOM,  ($urandom() << DIM_W) | b);
    write_reg(REG_FRAME_WIDTH,  ($urandom() << DIM_W) | fw);
    write_reg(REG_FRAME_HEIGHT, ($urandom() << DIM_W) | fh);
    write_reg(REG_PIXEL_MODE,   ($urandom() << DIM_W) | mode);
  endtask

  // block idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pixel_q.size() != 0 || pix_in_if.valid || placed_q.size() != 0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) pixel_q.push_back($urandom());
    wait_idle();
  endtask

  // frame side: mostly small, sometimes zero, full or oversized
  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1024;
      2:       return $urandom_range(1025, 2047);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic int unsigned pick_lo();
    case ($urandom_range(0, 7))
      0:       return 1023;
      1:       return $urandom_range(0, 1023);
      default: return $urandom_range(0, 24);
    endcase
  endfunction

  // upper bound: usually a few past the lower one, sometimes reversed
  function automatic int unsigned pick_hi(input int unsigned lo);
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1023);
      1:       return (lo > 0) ? lo - 1 : 0;
      default: return (lo + $urandom_range(0, 5) > 1023) ? 1023 : lo + $urandom_range(0, 5);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned sent, n, l, t;
    bit          hold_done;
    rst_ni              = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.reg_index    = REG_ROTATION;
    cfg_if.wr_data      = '0;
    pix_in_if.valid     = 1'b0;
    pix_in_if.pixel_in  = '0;
    pix_out_if.ready    = 1'b0;
    // predictor reset state
    geo_rot    = ROT_0;
    geo_left   = '0;
    geo_top    = '0;
    geo_right  = '0;
    geo_bottom = '0;
    geo_fw     = DIM_W'(1024);
    geo_fh     = DIM_W'(1024);
    geo_mode   = PM_16BPP;
    walk_col   = '0;
    walk_row   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: one-pixel area at the origin, 16bpp
    pixel_q.push_back(32'h0000_0000);
    pixel_q.push_back(32'hffff_ffff);
    wait_idle();

    // bottom-right corner of a full frame, highest index
    set_geom(ROT_0, 1022, 1022, 1023, 1023, 1024, 1024, PM_8BPP);
    pixel_q.push_back(32'hffff_ffff);
    pixel_q.push_back(32'h1234_5678);
    pixel_q.push_back(32'h0000_0000);
    pixel_q.push_back(32'ha5c3_0f96);
    wait_idle();

    // 90 degrees with byte swap
    set_geom(ROT_90, 0, 0, 2, 0, 16, 8, PM_16BPP_SWP);
    pixel_q.push_back(32'hffff_00ff);
    pixel_q.push_back(32'h0000_ff00);
    pixel_q.push_back(32'h5a5a_1234);
    wait_idle();

    // zero and oversized frame sizes, reversed columns, 24bpp
    set_geom(ROT_180, 3, 1, 1, 9, 2047, 0, PM_24BPP);
    pixel_q.push_back(32'hffff_ffff);
    pixel_q.push_back(32'h0102_0304);
    wait_idle();

    // bounds past a small frame, an unused mode code
    set_geom(ROT_270, 1023, 1023, 1023, 1023, 5, 7, 3'd6);
    pixel_q.push_back(32'hdead_beef);
    pixel_q.push_back(32'hffff_ffff);
    wait_idle();

    // walk partway, then shrink the area under the walk
    set_geom(ROT_0, 0, 0, 3, 1, 4, 4, PM_32BPP);
    pixel_q.push_back(32'h8000_0001);
    pixel_q.push_back(32'h7fff_fffe);
    pixel_q.push_back(32'hffff_ffff);
    wait_idle();
    write_reg(REG_AREA_RIGHT, 0);
    pixel_q.push_back(32'h0000_0000);
    pixel_q.push_back(32'hc0ff_ee00);
    wait_idle();

    // random phases
    sent      = 0;
    hold_done = 1'b0;
    while (sent < RAND_PIXELS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        // a few raw writes; the walk keeps its position
        repeat ($urandom_range(1, 3))
          write_reg(reg_index_e'($urandom_range(0, 7)), $urandom());
      end else begin
        l = pick_lo();
        t = pick_lo();
        set_geom(rotation_e'($urandom_range(0, 3)), l, t, pick_hi(l), pick_hi(t),
                 pick_dim(), pick_dim(), $urandom_range(0, 7));
      end
      n = $urandom_range(10, 60);
      if (!hold_done && sent > RAND_PIXELS / 2) begin
        // receiver holds off while the sender keeps pushing
        hold_done  = 1'b1;
        tx_idle_on = 1'b0;
        hold_left  = 300;
        n          = 80;
      end
      send_random(n);
      sent += n;
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && placed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== framebuffer_area_rotator.f =====
rtl/fbar_pkg.sv
rtl/fbar_if.sv
rtl/fbar_cfg.sv
rtl/fbar_walk.sv
rtl/fbar_index.sv
rtl/framebuffer_area_rotator.sv
tb/sv/framebuffer_area_rotator_tb.sv
